/* rtl/core/assert_macros.svh */
// Assertion macros shared by the encoder angle unwrap RTL.
// Clocked on clk, disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/core/eau_pkg.sv */
// Constants, types and helpers for the encoder angle unwrap block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package eau_pkg;

    localparam int TURN_BITS = 16;
    localparam int RAW_BITS  = 14;
    localparam int ANGLE_W   = 16;
    localparam int TURN_W    = 16;
    localparam int ABS_W     = 32;
    localparam int IN_W      = 16;
    localparam int OUT_W     = ANGLE_W + TURN_W + ABS_W;

    localparam logic [ANGLE_W-1:0] FULL_TURN   = 16'd36000;
    localparam logic [ANGLE_W-1:0] HALF_TURN   = 16'd18000;
    localparam logic [ABS_W-1:0]   TURN_OFFSET = 32'd36000;

    localparam logic [TURN_BITS-1:0] TURN_MAX = {1'b0, {(TURN_BITS-1){1'b1}}};
    localparam logic [TURN_BITS-1:0] TURN_MIN = {1'b1, {(TURN_BITS-1){1'b0}}};

    typedef logic [ANGLE_W-1:0]          angle_t;
    typedef logic signed [TURN_BITS-1:0] turns_t;

    // raw * 36000 / 16384, truncated
    function automatic angle_t scale_raw(input logic [RAW_BITS-1:0] raw);
        logic [RAW_BITS+ANGLE_W-1:0] prod;
        prod = {{RAW_BITS{1'b0}}, raw} * {{RAW_BITS{1'b0}}, FULL_TURN};
        return prod[RAW_BITS +: ANGLE_W];
    endfunction

    // clamp the counter to the signed range of the turn_count field
    function automatic logic [TURN_W-1:0] turn_field(input turns_t t);
        logic signed [31:0] w;
        w = 32'(t);
        if (w > 32'sd32767)
            w = 32'sd32767;
        else if (w < -32'sd32768)
            w = -32'sd32768;
        return w[TURN_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/encoder_angle_unwrap.sv */
// Encoder angle unwrap: 14-bit raw angle to hundredths of a degree plus turn count.
// Stages: input register, unwrap logic, output register.
// Throughput: one word per clock unless m_tready stalls the output.
// Reset (rst_n low, asynchronous): pipeline empty, previous angle, turns and invert cleared.
// Depends on eau_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module encoder_angle_unwrap
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_wr_en,
    input  wire logic                       cfg_wr_data,    // invert_direction
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [eau_pkg::IN_W-1:0]   s_tdata,        // [15:0] response_word
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [eau_pkg::OUT_W-1:0]       m_tdata         // [15:0] wrapped_angle,
                                                            // [31:16] turn_count,
                                                            // [63:32] absolute_angle
);

    import eau_pkg::*;

    logic                 invert_reg;
    logic                 s1_valid_reg;
    angle_t               s1_angle_reg;
    logic                 out_valid_reg;
    logic [OUT_W-1:0]     out_data_reg;
    angle_t               prev_angle_reg;
    turns_t               turns_reg;
    logic [ABS_W-1:0]     offset_reg;

    angle_t               in_angle;
    angle_t               in_scaled;
    logic                 out_free;
    logic                 s1_adv;
    logic                 in_acc;
    logic signed [ANGLE_W:0] delta;
    turns_t               turns_next;
    logic [ABS_W-1:0]     offset_next;
    logic [ABS_W-1:0]     abs_angle;

    assign out_free = !out_valid_reg || m_tready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;
    assign in_acc   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        in_scaled = scale_raw(s_tdata[RAW_BITS-1:0]);
        if (invert_reg && (in_scaled != '0))
            in_angle = FULL_TURN - in_scaled;
        else
            in_angle = in_scaled;
    end

    always_comb
    begin
        delta       = $signed({1'b0, s1_angle_reg}) - $signed({1'b0, prev_angle_reg});
        turns_next  = turns_reg;
        offset_next = offset_reg;
        if ((delta > $signed({1'b0, HALF_TURN})) && (turns_reg != TURN_MIN))
        begin
            turns_next  = turns_reg - turns_t'(1);
            offset_next = offset_reg - TURN_OFFSET;
        end
        else if ((delta < -$signed({1'b0, HALF_TURN})) && (turns_reg != TURN_MAX))
        begin
            turns_next  = turns_reg + turns_t'(1);
            offset_next = offset_reg + TURN_OFFSET;
        end
        abs_angle = offset_next + ABS_W'(s1_angle_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            invert_reg     <= 1'b0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            prev_angle_reg <= '0;
            turns_reg      <= '0;
            offset_reg     <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                invert_reg <= cfg_wr_data;
            if (s_tready)
                s1_valid_reg <= s_tvalid;
            if (out_free)
                out_valid_reg <= s1_valid_reg;
            if (s1_adv)
            begin
                prev_angle_reg <= s1_angle_reg;
                turns_reg      <= turns_next;
                offset_reg     <= offset_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
            s1_angle_reg <= in_angle;
        if (s1_adv)
            out_data_reg <= {abs_angle, turn_field(turns_next), s1_angle_reg};
    end

    `ASSERT_CLK(a_angle_range, !m_tvalid || (m_tdata[ANGLE_W-1:0] < FULL_TURN))
    `ASSERT_NEXT(a_turns_hold, !s1_adv, $stable(turns_reg) && $stable(offset_reg))
    `ASSERT_NEXT(a_result_follows, s1_adv, m_tvalid)

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// Self-checking bench for encoder_angle_unwrap: directed words, then random and spin runs.
// Results are checked word by word against the directed table or an unwrap predictor.
// Depends on eau_pkg and the encoder_angle_unwrap RTL.
`timescale 1ns / 1ps

module tb_top;

    import eau_pkg::*;

    localparam int     STALL_LONG = 300;
    localparam int     WATCHDOG   = 2000;
    localparam int     SPIN_TURNS = 10;
    localparam longint TURN_TOP   = (longint'(1) <<< (TURN_BITS - 1)) - 1;
    localparam longint TURN_FLOOR = -TURN_TOP - 1;

    // lowest field in the lowest bits, as on m_tdata
    typedef struct packed {
        logic signed [31:0] absolute;
        logic signed [15:0] turns;
        logic [15:0]        angle;
    } unwrap_res_t;

    typedef struct {
        logic        inv;
        logic [15:0] word;
        bit          given;
        unwrap_res_t res;
    } dir_row_t;

    typedef struct {
        bit          given;
        unwrap_res_t res;
    } typed_res_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic                cfg_wr_data = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata = '0;      // [15:0] response_word
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_W-1:0]    m_tdata;           // [15:0] wrapped_angle, [31:16] turn_count,
                                            // [63:32] absolute_angle

    // predictor state
    bit                  inv_mode = 1'b0;
    int                  prev_deg = 0;
    longint              turn_ctr = 0;

    unwrap_res_t         unwrap_due[$];
    typed_res_t          typed_due[$];
    dir_row_t            dir_rows[17];

    logic [13:0]         last_raw = '0;
    bit                  tx_gaps_on = 1'b1;
    bit                  rx_gaps_on = 1'b1;
    bit                  rx_hold_req = 1'b0;
    int                  mismatches = 0;
    int                  quiet_cycles = 0;

    encoder_angle_unwrap DUT
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 0;
    end

    function automatic unwrap_res_t unwrap_predict(input logic [15:0] word);
        logic [29:0] prod;
        int          deg;
        int          diff;
        longint      shown;
        longint      absolute;
        unwrap_res_t r;
        prod = 30'(word[13:0]) * 30'd36000;
        deg  = int'(prod >> 14);
        if (inv_mode)
        begin
            deg = 36000 - deg;
            if (deg >= 36000)
                deg = deg - 36000;
        end
        diff = deg - prev_deg;
        if (diff > 18000 && turn_ctr > TURN_FLOOR)
            turn_ctr = turn_ctr - 1;
        if (diff < -18000 && turn_ctr < TURN_TOP)
            turn_ctr = turn_ctr + 1;
        prev_deg = deg;
        shown = turn_ctr;
        if (shown > 32767)
            shown = 32767;
        if (shown < -32768)
            shown = -32768;
        absolute   = longint'(deg) + turn_ctr * 36000;
        r.angle    = 16'(deg);
        r.turns    = 16'(shown);
        r.absolute = 32'(absolute);
        return r;
    endfunction

    function automatic logic [15:0] next_word();
        logic [13:0] raw;
        int          pick;
        pick = $urandom_range(0, 9);
        if (pick <= 3)
            raw = 14'($urandom_range(0, 16383));
        else if (pick <= 6)
            raw = last_raw + 14'($urandom_range(0, 6000)) - 14'd3000;
        else if (pick == 7)
            raw = last_raw + 14'd8192;      // exactly half a turn either way
        else if (pick == 8)
            raw = last_raw + ($urandom_range(0, 1) ? 14'd8191 : 14'd8193);
        else
        begin
            case ($urandom_range(0, 4))
                0:       raw = 14'd0;
                1:       raw = 14'd1;
                2:       raw = 14'd8191;
                3:       raw = 14'd8192;
                default: raw = 14'd16383;
            endcase
        end
        return {2'($urandom_range(0, 3)), raw};
    endfunction

    // bands chosen so that only the C-to-A (or A-to-C) step crosses half a turn
    function automatic logic [15:0] band_word(input int band);
        logic [13:0] raw;
        if (band == 0)
            raw = 14'($urandom_range(0, 1023));
        else if (band == 1)
            raw = 14'($urandom_range(4096, 5500));
        else
            raw = 14'($urandom_range(10240, 12000));
        return {2'($urandom_range(0, 3)), raw};
    endfunction

    task automatic put_word(input logic [15:0] w);
        int gap;
        if (tx_gaps_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 19);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        last_raw = w[13:0];
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (unwrap_due.size() != 0);
    endtask

    task automatic reconfigure(input bit inv);
        drain_results();
        repeat (3) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= inv;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        inv_mode = inv;
    endtask

    task automatic run_random(input int count);
        repeat (count)
            put_word(next_word());
    endtask

    // input side: predict each accepted word
    always @(posedge clk)
    begin : accept_mon
        unwrap_res_t p;
        typed_res_t  t;
        if (rst_n && s_tvalid && s_tready)
        begin
            p = unwrap_predict(s_tdata);
            if (typed_due.size() != 0)
            begin
                t = typed_due.pop_front();
                if (t.given)
                    p = t.res;
            end
            unwrap_due.push_back(p);
        end
    end

    // output side: compare against the oldest expectation
    always @(posedge clk)
    begin : result_mon
        unwrap_res_t e;
        unwrap_res_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (unwrap_due.size() == 0)
            begin
                $error("unexpected result word 0x%h", m_tdata);
                mismatches++;
            end
            else
            begin
                e = unwrap_due.pop_front();
                if (got.angle !== e.angle)
                begin
                    $error("wrapped_angle: expected %0d, got %0d", e.angle, got.angle);
                    mismatches++;
                end
                if (got.turns !== e.turns)
                begin
                    $error("turn_count: expected %0d, got %0d", e.turns, got.turns);
                    mismatches++;
                end
                if (got.absolute !== e.absolute)
                begin
                    $error("absolute_angle: expected %0d, got %0d", e.absolute, got.absolute);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial
    begin : sink
        int n;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (STALL_LONG - 1) @(posedge clk);
            end
            else if (rx_gaps_on && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 19);
                m_tready <= 1'b0;
                repeat (n - 1) @(posedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        typed_res_t t;
        dir_rows = '{
            '{1'b0, 16'h3FFF, 1'b1, '{-32'sd3,     -16'sd1, 16'd35997}},
            '{1'b0, 16'h0000, 1'b1, '{32'sd0,      16'sd0,  16'd0}},
            '{1'b0, 16'h2000, 1'b1, '{32'sd18000,  16'sd0,  16'd18000}},
            '{1'b0, 16'hC000, 1'b1, '{32'sd0,      16'sd0,  16'd0}},
            '{1'b0, 16'hFFFF, 1'b1, '{-32'sd3,     -16'sd1, 16'd35997}},
            '{1'b0, 16'h8000, 1'b1, '{32'sd0,      16'sd0,  16'd0}},
            '{1'b0, 16'h2001, 1'b1, '{-32'sd17998, -16'sd1, 16'd18002}},
            '{1'b0, 16'h4000, 1'b1, '{32'sd0,      16'sd0,  16'd0}},
            '{1'b0, 16'h1555, 1'b0, '{32'sd0,      16'sd0,  16'd0}},
            '{1'b0, 16'h2AAA, 1'b0, '{32'sd0,      16'sd0,  16'd0}},
            '{1'b0, 16'h0AAA, 1'b0, '{32'sd0,      16'sd0,  16'd0}},
            '{1'b1, 16'h0000, 1'b1, '{32'sd0,      16'sd0,  16'd0}},
            '{1'b1, 16'h3FFF, 1'b1, '{32'sd3,      16'sd0,  16'd3}},
            '{1'b1, 16'h0001, 1'b1, '{-32'sd2,     -16'sd1, 16'd35998}},
            '{1'b1, 16'h3FFF, 1'b1, '{32'sd3,      16'sd0,  16'd3}},
            '{1'b1, 16'h6000, 1'b0, '{32'sd0,      16'sd0,  16'd0}},
            '{1'b0, 16'hB123, 1'b0, '{32'sd0,      16'sd0,  16'd0}}
        };
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words; the first one after reset lands above half a turn
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].inv != inv_mode)
                reconfigure(dir_rows[i].inv);
            t.given = dir_rows[i].given;
            t.res   = dir_rows[i].res;
            typed_due.push_back(t);
            put_word(dir_rows[i].word);
        end

        reconfigure(1'b1);
        run_random(60);
        tx_gaps_on  = 1'b0;
        rx_hold_req = 1'b1;
        run_random(40);
        tx_gaps_on = 1'b1;
        run_random(50);
        drain_results();
        run_random(100);
        reconfigure(1'b0);
        run_random(200);
        reconfigure(1'b1);
        run_random(200);

        // spin the counter up SPIN_TURNS turns, then down twice as many
        reconfigure(1'b0);
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        repeat (SPIN_TURNS)
        begin
            put_word(band_word(1));
            put_word(band_word(2));
            put_word(band_word(0));
        end
        repeat (2 * SPIN_TURNS)
        begin
            put_word(band_word(2));
            put_word(band_word(1));
            put_word(band_word(0));
        end

        reconfigure(1'($urandom_range(0, 1)));
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
        run_random(250);
        reconfigure(1'b1);
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        run_random(250);

        drain_results();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
